// ===== design/ctc_pkg.sv =====
// shared types and constants for the counter/timer channel rate unit
`default_nettype none

package ctc_pkg;

    localparam int NUM_CHANNELS = 4;
    localparam int IDX_W        = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

    localparam int DATA_W = 32;
    localparam int DSR_W  = 9;
    localparam int STEP_W = $clog2(DATA_W);

    // control word bit positions
    localparam int CW_CONTROL   = 0;
    localparam int CW_RESET     = 1;
    localparam int CW_TCFOLLOWS = 2;
    localparam int CW_MANUAL    = 3;
    localparam int CW_RISING    = 4;
    localparam int CW_PRE256    = 5;
    localparam int CW_COUNTER   = 6;

    localparam int PRE16_SHIFT  = 4;
    localparam int PRE256_SHIFT = 8;

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_QUERY = 2'd1,
        OP_CLEAR = 2'd2,
        OP_RSVD  = 2'd3
    } opcode_t;

    typedef struct packed {
        logic [7:0]       ctrl;
        logic [DSR_W-1:0] tc;
        logic [DSR_W-1:0] cnt;
        logic             running;
    } chan_view_t;

    typedef struct packed {
        logic       wr_en;
        logic       clr_all;
        logic [7:0] data;
    } reg_cmd_t;

endpackage

`default_nettype wire

// ===== design/ctc_divider.sv =====
// shared radix-2 restoring divider, 32-bit dividend by 9-bit divisor
`default_nettype none

module ctc_divider (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic [ctc_pkg::DATA_W-1:0]  dividend,
    input  wire logic [ctc_pkg::DSR_W-1:0]   divisor,
    output logic                             busy,
    output logic                             done,
    output logic [ctc_pkg::DATA_W-1:0]       quotient
);

    logic [ctc_pkg::DATA_W-1:0] quo_reg, quo_next;
    logic [ctc_pkg::DSR_W-1:0]  rem_reg, rem_next;
    logic [ctc_pkg::DSR_W-1:0]  dsr_reg, dsr_next;
    logic [ctc_pkg::STEP_W-1:0] step_reg, step_next;
    logic                       busy_reg, busy_next;
    logic                       done_reg, done_next;
    logic [ctc_pkg::DSR_W:0]    trial;
    logic                       fits;

    assign trial = {rem_reg, quo_reg[ctc_pkg::DATA_W-1]};
    assign fits  = (trial >= {1'b0, dsr_reg});

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
            step_next = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // one quotient bit per cycle
            if (fits)
            begin
                rem_next = ctc_pkg::DSR_W'(trial - {1'b0, dsr_reg});
            end
            else
            begin
                rem_next = trial[ctc_pkg::DSR_W-1:0];
            end
            quo_next  = {quo_reg[ctc_pkg::DATA_W-2:0], fits};
            step_next = step_reg + 1'b1;
            if (step_reg == ctc_pkg::STEP_W'(ctc_pkg::DATA_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = quo_reg;

    a_start_busy : assert property (@(posedge clk) disable iff (!rst_n)
        start |=> busy_reg)
        else $error("divider not busy after start");

    a_done_idle : assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg && $past(busy_reg))
        else $error("divider done without a finished run");

    a_run_len : assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg && !start && step_reg != ctc_pkg::STEP_W'(ctc_pkg::DATA_W - 1) |=> busy_reg)
        else $error("divider stopped early");

endmodule

`default_nettype wire

// ===== design/ctc_regfile.sv =====
// per-channel control, time constant, count and running flag registers
`default_nettype none

module ctc_regfile (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic [ctc_pkg::IDX_W-1:0]  idx,
    input  wire ctc_pkg::reg_cmd_t          cmd,
    output ctc_pkg::chan_view_t             view
);

    logic [7:0]                ctrl_reg  [ctc_pkg::NUM_CHANNELS];
    logic                      await_reg [ctc_pkg::NUM_CHANNELS];
    logic [ctc_pkg::DSR_W-1:0] tc_reg    [ctc_pkg::NUM_CHANNELS];
    logic [ctc_pkg::DSR_W-1:0] cnt_reg   [ctc_pkg::NUM_CHANNELS];
    logic                      run_reg   [ctc_pkg::NUM_CHANNELS];

    logic [ctc_pkg::DSR_W-1:0] tc_load;

    // a zero byte loads a constant of 256
    assign tc_load = (cmd.data == 8'd0) ? ctc_pkg::DSR_W'(256) : {1'b0, cmd.data};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ctc_pkg::NUM_CHANNELS; i++)
            begin
                ctrl_reg[i]  <= '0;
                await_reg[i] <= 1'b0;
                tc_reg[i]    <= '0;
                cnt_reg[i]   <= '0;
                run_reg[i]   <= 1'b0;
            end
        end
        else if (cmd.clr_all)
        begin
            for (int i = 0; i < ctc_pkg::NUM_CHANNELS; i++)
            begin
                ctrl_reg[i]  <= '0;
                await_reg[i] <= 1'b0;
                tc_reg[i]    <= '0;
                cnt_reg[i]   <= '0;
                run_reg[i]   <= 1'b0;
            end
        end
        else if (cmd.wr_en)
        begin
            if (cmd.data[ctc_pkg::CW_CONTROL])
            begin
                ctrl_reg[idx]  <= cmd.data;
                await_reg[idx] <= cmd.data[ctc_pkg::CW_TCFOLLOWS];
                if (cmd.data[ctc_pkg::CW_RESET])
                begin
                    cnt_reg[idx] <= '0;
                    run_reg[idx] <= 1'b0;
                end
            end
            else if (await_reg[idx])
            begin
                tc_reg[idx]    <= tc_load;
                cnt_reg[idx]   <= tc_load;
                await_reg[idx] <= 1'b0;
                run_reg[idx]   <= !ctrl_reg[idx][ctc_pkg::CW_MANUAL];
            end
        end
    end

    assign view.ctrl    = ctrl_reg[idx];
    assign view.tc      = tc_reg[idx];
    assign view.cnt     = cnt_reg[idx];
    assign view.running = run_reg[idx];

endmodule

`default_nettype wire

// ===== design/ctc_channel_rate_unit.sv =====
// top level: sequencer over the channel registers and the shared divider
//
// Four-channel counter/timer register model that answers rate queries.
// Input channel (in_valid/in_ready) carries opcode, chan_sel, data_byte and
// input_frequency; output channel (out_valid/out_ready) returns rate_out and
// is_running, exactly one result per input transfer, in order.
// One item is handled at a time: in_ready is high only while the sequencer
// is idle and the output register is empty.
// Register write, reset-all and reserved opcodes pass through S_EXEC and S_DONE,
// which registers the result. Rate query on a timer channel: one pass through
// the shared 1-bit-per-cycle divider. Each rising-edge counter level below the
// queried channel adds an S_WALK step, an S_SETUP step and another division.
// A query that comes out 0 without dividing passes S_WALK once per channel
// walked down, then S_FINISH and S_DONE.
// Reset clears all channel registers, the sequencer state and out_valid;
// rate_out and is_running are not reset.
// When the receiver stalls, the result holds in the output register and no
// new input transfer is taken until it has been delivered.
`default_nettype none

module ctc_channel_rate_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  opcode,
    input  wire logic [1:0]  chan_sel,
    input  wire logic [7:0]  data_byte,
    input  wire logic [31:0] input_frequency,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [31:0]      rate_out,
    output logic             is_running
);

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_EXEC   = 7'b0000010,
        S_WALK   = 7'b0000100,
        S_DIV    = 7'b0001000,
        S_SETUP  = 7'b0010000,
        S_FINISH = 7'b0100000,
        S_DONE   = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    logic [ctc_pkg::IDX_W-1:0]  ch_reg, ch_next;
    logic [ctc_pkg::IDX_W-1:0]  cur_reg, cur_next;
    logic [ctc_pkg::IDX_W-1:0]  depth_reg, depth_next;
    logic                       ok_reg, ok_next;
    ctc_pkg::opcode_t           op_reg, op_next;
    logic [7:0]                 data_reg, data_next;
    logic [31:0]                freq_reg, freq_next;
    logic [31:0]                acc_reg, acc_next;
    logic                       out_valid_reg, out_valid_next;
    logic [31:0]                rate_reg, rate_next;
    logic                       run_out_reg, run_out_next;

    logic                       accept;
    logic                       chan_ok;
    ctc_pkg::reg_cmd_t          cmd;
    ctc_pkg::chan_view_t        view;

    logic                       div_start;
    logic [31:0]                div_dividend;
    logic [ctc_pkg::DSR_W-1:0]  div_divisor;
    logic                       div_busy;
    logic                       div_done;
    logic [31:0]                div_quotient;

    assign in_ready = (state_reg == S_IDLE) && !out_valid_reg;
    assign accept   = in_valid && in_ready;
    assign chan_ok  = ({30'd0, chan_sel} < 32'(ctc_pkg::NUM_CHANNELS));

    ctc_regfile u_regs (
        .clk   (clk),
        .rst_n (rst_n),
        .idx   (cur_reg),
        .cmd   (cmd),
        .view  (view)
    );

    ctc_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_quotient)
    );

    always_comb
    begin
        state_next     = state_reg;
        ch_next        = ch_reg;
        cur_next       = cur_reg;
        depth_next     = depth_reg;
        ok_next        = ok_reg;
        op_next        = op_reg;
        data_next      = data_reg;
        freq_next      = freq_reg;
        acc_next       = acc_reg;
        out_valid_next = out_valid_reg;
        rate_next      = rate_reg;
        run_out_next   = run_out_reg;
        cmd            = '0;
        cmd.data       = data_reg;
        div_start      = 1'b0;
        div_dividend   = acc_reg;
        div_divisor    = view.cnt;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    ch_next    = ctc_pkg::IDX_W'(chan_sel);
                    cur_next   = ctc_pkg::IDX_W'(chan_sel);
                    depth_next = '0;
                    ok_next    = chan_ok;
                    op_next    = ctc_pkg::opcode_t'(opcode);
                    data_next  = data_byte;
                    freq_next  = input_frequency;
                    acc_next   = '0;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_DONE;
                case (op_reg)
                    ctc_pkg::OP_WRITE: cmd.wr_en   = ok_reg;
                    ctc_pkg::OP_CLEAR: cmd.clr_all = 1'b1;
                    ctc_pkg::OP_QUERY:
                    begin
                        if (ok_reg)
                        begin
                            state_next = S_WALK;
                        end
                    end
                    default: ;
                endcase
            end
            S_WALK:
            begin
                if (view.ctrl[ctc_pkg::CW_COUNTER])
                begin
                    // counter mode takes the rate of the channel below; falling edge, channel 0 or a zero count gives 0
                    if (!view.ctrl[ctc_pkg::CW_RISING] || cur_reg == '0 || view.cnt == '0)
                    begin
                        acc_next   = '0;
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        cur_next   = cur_reg - 1'b1;
                        depth_next = depth_reg + 1'b1;
                    end
                end
                else if (view.tc == '0)
                begin
                    acc_next   = '0;
                    state_next = S_FINISH;
                end
                else
                begin
                    // freq / (tc * 2^k) == (freq >> k) / tc
                    div_start   = 1'b1;
                    div_divisor = view.tc;
                    if (view.ctrl[ctc_pkg::CW_PRE256])
                    begin
                        div_dividend = freq_reg >> ctc_pkg::PRE256_SHIFT;
                    end
                    else
                    begin
                        div_dividend = freq_reg >> ctc_pkg::PRE16_SHIFT;
                    end
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    acc_next = div_quotient;
                    if (depth_reg == '0)
                    begin
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        cur_next   = cur_reg + 1'b1;
                        depth_next = depth_reg - 1'b1;
                        state_next = S_SETUP;
                    end
                end
            end
            S_SETUP:
            begin
                // count was checked nonzero on the way down
                div_start    = 1'b1;
                div_dividend = acc_reg;
                div_divisor  = view.cnt;
                state_next   = S_DIV;
            end
            S_FINISH:
            begin
                cur_next   = ch_reg;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                out_valid_next = 1'b1;
                rate_next      = acc_reg;
                run_out_next   = ok_reg && view.running;
                state_next     = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            cur_reg       <= '0;
            depth_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            cur_reg       <= cur_next;
            depth_reg     <= depth_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ch_reg      <= ch_next;
        ok_reg      <= ok_next;
        op_reg      <= op_next;
        data_reg    <= data_next;
        freq_reg    <= freq_next;
        acc_reg     <= acc_next;
        rate_reg    <= rate_next;
        run_out_reg <= run_out_next;
    end

    assign out_valid  = out_valid_reg;
    assign rate_out   = rate_reg;
    assign is_running = run_out_reg;

    a_busy_after_take : assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !in_ready)
        else $error("input taken while an item is in flight");

    a_div_running : assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DIV |-> div_busy || div_done)
        else $error("waiting on an idle divider");

    a_chain_index : assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WALK || state_reg == S_DIV || state_reg == S_SETUP) |->
        ({1'b0, cur_reg} + {1'b0, depth_reg} == {1'b0, ch_reg}))
        else $error("chain index out of step with queried channel");

    a_one_result : assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DONE |-> !out_valid_reg || out_ready)
        else $error("result would overwrite an undelivered one");

endmodule

`default_nettype wire
